>>> sv/cmc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmc_pkg
// Shared types and constants for the complex matched correlator.
// ----------------------------------------------------------------------------
package cmc_pkg;

  localparam int TAP_COUNT_DEF = 64;
  localparam int SAMPLE_W      = 16;
  localparam int TAP_IDX_W     = 6;
  localparam int TAP_IDX_DEPTH = 2 ** TAP_IDX_W;
  localparam int GAIN_W        = 24;
  localparam int FRAC_SHIFT    = 16;
  localparam int COMP_W        = 31;
  localparam int MAG_W         = COMP_W + FRAC_SHIFT;
  localparam int SQ_W          = 2 * COMP_W;
  localparam int SCORE_W       = SQ_W + 1;

  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(65536);

  localparam logic FUNC_TAP    = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] re;
    logic signed [SAMPLE_W-1:0] im;
  } cplx_t;

  typedef struct packed {
    logic shift;
    logic rotate;
    logic tap_wr;
  } cell_ctl_t;

endpackage

>>> sv/cmc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmc_if
// Valid/ready channels of the correlator: input items, scores, gain writes.
// ----------------------------------------------------------------------------
interface cmc_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  func;
  logic [cmc_pkg::TAP_IDX_W-1:0]         tap_index;
  logic signed [cmc_pkg::SAMPLE_W-1:0]   tap_re;
  logic signed [cmc_pkg::SAMPLE_W-1:0]   tap_im;
  logic signed [cmc_pkg::SAMPLE_W-1:0]   sample_re;
  logic signed [cmc_pkg::SAMPLE_W-1:0]   sample_im;
  logic                                  block_start;

  modport source (output valid, func, tap_index, tap_re, tap_im, sample_re, sample_im,
                  block_start, input ready);
  modport sink (input valid, func, tap_index, tap_re, tap_im, sample_re, sample_im,
                block_start, output ready);
endinterface

interface cmc_out_if;
  logic                         valid;
  logic                         ready;
  logic [cmc_pkg::SCORE_W-1:0]  score;

  modport source (output valid, score, input ready);
  modport sink (input valid, score, output ready);
endinterface

interface cmc_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [cmc_pkg::GAIN_W-1:0]   gain_scale;

  modport source (output valid, gain_scale, input ready);
  modport sink (input valid, gain_scale, output ready);
endinterface

>>> sv/cmc_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmc_cell
// One delay-line cell: holds a sample and a tap, takes both from its neighbor.
// ----------------------------------------------------------------------------
module cmc_cell (
  input  logic               clk,
  input  cmc_pkg::cell_ctl_t ctl,
  input  cmc_pkg::cplx_t     sample_in,
  input  cmc_pkg::cplx_t     tap_in,
  input  cmc_pkg::cplx_t     tap_wdata,
  output cmc_pkg::cplx_t     sample_q,
  output cmc_pkg::cplx_t     tap_q
);

  cmc_pkg::cplx_t sample_r;
  cmc_pkg::cplx_t tap_r;

  always_ff @(posedge clk) begin
    if (ctl.shift || ctl.rotate) begin
      sample_r <= sample_in;
    end
    if (ctl.rotate) begin
      tap_r <= tap_in;
    end else if (ctl.tap_wr) begin
      tap_r <= tap_wdata;
    end
  end

  assign sample_q = sample_r;
  assign tap_q    = tap_r;

endmodule

>>> sv/cmc_comp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmc_comp
// Scales one accumulator component, rounds, saturates and squares it.
// Four register stages.
// ----------------------------------------------------------------------------
module cmc_comp #(
  parameter int ACC_W = 40
) (
  input  logic                             clk,
  input  logic signed [ACC_W-1:0]          acc,
  input  logic [cmc_pkg::GAIN_W-1:0]       gain,
  output logic [cmc_pkg::SQ_W-1:0]         sq
);

  localparam int MAG_W  = cmc_pkg::MAG_W;
  localparam int LO_W   = cmc_pkg::GAIN_W;
  localparam int HI_W   = MAG_W - LO_W;
  localparam int PLO_W  = LO_W + cmc_pkg::GAIN_W;
  localparam int PHI_W  = HI_W + cmc_pkg::GAIN_W;
  localparam int SUM_W  = PHI_W + LO_W + 1;
  localparam int Q_W    = SUM_W - cmc_pkg::FRAC_SHIFT;
  localparam int COMP_W = cmc_pkg::COMP_W;
  localparam logic [Q_W-1:0] COMP_MAX = Q_W'({COMP_W{1'b1}});
  localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (cmc_pkg::FRAC_SHIFT - 1);

  logic [ACC_W-1:0] mag;
  logic [MAG_W-1:0] mag_trim;
  logic             big;

  always_comb begin
    mag = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
  end

  if (ACC_W > MAG_W) begin : g_wide
    assign big      = |mag[ACC_W-1:MAG_W];
    assign mag_trim = mag[MAG_W-1:0];
  end else begin : g_narrow
    assign big      = 1'b0;
    assign mag_trim = MAG_W'(mag);
  end

  logic [LO_W-1:0]   lo_r;
  logic [HI_W-1:0]   hi_r;
  logic              big_r;
  logic [PLO_W-1:0]  plo_r;
  logic [PHI_W-1:0]  phi_r;
  logic              sat_r;
  logic [COMP_W-1:0] q_r;
  logic [cmc_pkg::SQ_W-1:0] sq_r;
  logic [SUM_W-1:0]  sum;
  logic [Q_W-1:0]    q_full;

  always_comb begin
    sum    = SUM_W'(plo_r) + {1'b0, phi_r, {LO_W{1'b0}}} + ROUND_HALF;
    q_full = sum[SUM_W-1:cmc_pkg::FRAC_SHIFT];
  end

  always_ff @(posedge clk) begin
    lo_r  <= mag_trim[LO_W-1:0];
    hi_r  <= mag_trim[MAG_W-1:LO_W];
    big_r <= big;
    plo_r <= PLO_W'(lo_r) * PLO_W'(gain);
    phi_r <= PHI_W'(hi_r) * PHI_W'(gain);
    sat_r <= big_r && (gain != '0);
    if (sat_r || (q_full > COMP_MAX)) begin
      q_r <= COMP_MAX[COMP_W-1:0];
    end else begin
      q_r <= q_full[COMP_W-1:0];
    end
    sq_r  <= cmc_pkg::SQ_W'(q_r) * cmc_pkg::SQ_W'(q_r);
  end

  assign sq = sq_r;

endmodule

>>> sv/complex_matched_correlator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_matched_correlator
// Sliding complex correlation against loaded taps, scaled, saturated and
// reported as magnitude squared.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                            | handshake
//  in_ch    | in  | func tap_index tap_re tap_im sample_re sample_im   | valid/ready
//           |     | block_start                                        |
//  out_ch   | out | score                                              | valid/ready
//  cfg_ch   | in  | gain_scale                                         | valid/ready
//
//  Tap writes and samples of a partial window leave in_ch ready.
//  A sample that completes a window drops in_ch ready: the cell ring
//  rotates once through the single complex MAC, then the sums are scaled.
//  out_ch is registered; a new item is taken while a score waits, and the
//  block stalls at the end of the next score until out_ch drains.
//  rst_n is synchronous; it clears fill count, control and gain (1.0).
// ----------------------------------------------------------------------------
module complex_matched_correlator #(
  parameter int TAP_COUNT = cmc_pkg::TAP_COUNT_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  cmc_in_if.sink    in_ch,
  cmc_out_if.source out_ch,
  cmc_cfg_if.sink   cfg_ch
);

  localparam int FILL_W   = $clog2(TAP_COUNT + 1);
  localparam int ACC_W    = 2 * cmc_pkg::SAMPLE_W + 2 + $clog2(TAP_COUNT);
  localparam int POST_LEN = 5;
  localparam int CNT_MAX  = (TAP_COUNT > POST_LEN) ? TAP_COUNT : POST_LEN;
  localparam int CNT_W    = (CNT_MAX > 1) ? $clog2(CNT_MAX) : 1;
  localparam int PROD_W   = 2 * cmc_pkg::SAMPLE_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MAC  = 2'd1;
  localparam logic [1:0] ST_POST = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [cmc_pkg::GAIN_W-1:0] gain_r;

  logic in_acc, smp_acc, tap_acc, win_full, out_load;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_acc  = in_ch.valid && in_ch.ready;
  assign smp_acc = in_acc && (in_ch.func == cmc_pkg::FUNC_SAMPLE);
  assign tap_acc = in_acc && (in_ch.func == cmc_pkg::FUNC_TAP);

  always_comb begin
    fill_nxt = in_ch.block_start ? '0 : fill_r;
    if (fill_nxt < FILL_W'(TAP_COUNT)) begin
      fill_nxt = fill_nxt + FILL_W'(1);
    end
  end
  assign win_full = (fill_nxt == FILL_W'(TAP_COUNT));
  assign out_load = (state_r == ST_FIN) && (!out_ch.valid || out_ch.ready);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (smp_acc && win_full) begin
          state_nxt = ST_MAC;
          cnt_nxt   = '0;
        end
      end
      ST_MAC: begin
        if (cnt_r == CNT_W'(TAP_COUNT - 1)) begin
          state_nxt = ST_POST;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      ST_POST: begin
        if (cnt_r == CNT_W'(POST_LEN - 1)) begin
          state_nxt = ST_FIN;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      ST_FIN: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      fill_r  <= '0;
      gain_r  <= cmc_pkg::GAIN_RESET;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (smp_acc) begin
        fill_r <= fill_nxt;
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        gain_r <= cfg_ch.gain_scale;
      end
    end
  end

  // cell ring, index 0 is the oldest sample and feeds the MAC
  cmc_pkg::cplx_t    smp_q [TAP_COUNT];
  cmc_pkg::cplx_t    tap_q [TAP_COUNT];
  cmc_pkg::cplx_t    new_smp, new_tap;
  logic              rot;

  assign rot     = (state_r == ST_MAC);
  assign new_smp = '{re: in_ch.sample_re, im: in_ch.sample_im};
  assign new_tap = '{re: in_ch.tap_re, im: in_ch.tap_im};

  for (genvar k = 0; k < TAP_COUNT; k++) begin : g_cell
    cmc_pkg::cell_ctl_t ctl;
    cmc_pkg::cplx_t     smp_in, tap_in;

    assign ctl.shift  = smp_acc;
    assign ctl.rotate = rot;
    assign ctl.tap_wr = tap_acc && (k < cmc_pkg::TAP_IDX_DEPTH) &&
                        (in_ch.tap_index == cmc_pkg::TAP_IDX_W'(k));

    if (k == TAP_COUNT - 1) begin : g_tail
      assign smp_in = rot ? smp_q[0] : new_smp;
      assign tap_in = tap_q[0];
    end else begin : g_body
      assign smp_in = smp_q[k+1];
      assign tap_in = tap_q[k+1];
    end

    cmc_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .sample_in (smp_in),
      .tap_in    (tap_in),
      .tap_wdata (new_tap),
      .sample_q  (smp_q[k]),
      .tap_q     (tap_q[k])
    );
  end

  // complex MAC
  logic signed [PROD_W-1:0] mul_rr_r, mul_ii_r, mul_ri_r, mul_ir_r;
  logic signed [PROD_W:0]   term_re, term_im;
  logic signed [ACC_W-1:0]  acc_re_r, acc_im_r;
  logic                     mac_en_r;

  assign term_re = (PROD_W+1)'(mul_rr_r) - (PROD_W+1)'(mul_ii_r);
  assign term_im = (PROD_W+1)'(mul_ri_r) + (PROD_W+1)'(mul_ir_r);

  always_ff @(posedge clk) begin
    mul_rr_r <= smp_q[0].re * tap_q[0].re;
    mul_ii_r <= smp_q[0].im * tap_q[0].im;
    mul_ri_r <= smp_q[0].re * tap_q[0].im;
    mul_ir_r <= smp_q[0].im * tap_q[0].re;
    if (smp_acc) begin
      acc_re_r <= '0;
      acc_im_r <= '0;
    end else if (mac_en_r) begin
      acc_re_r <= acc_re_r + ACC_W'(term_re);
      acc_im_r <= acc_im_r + ACC_W'(term_im);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mac_en_r <= 1'b0;
    end else begin
      mac_en_r <= rot;
    end
  end

  logic [cmc_pkg::SQ_W-1:0] sq_re, sq_im;

  cmc_comp #(.ACC_W(ACC_W)) u_comp_re (
    .clk  (clk),
    .acc  (acc_re_r),
    .gain (gain_r),
    .sq   (sq_re)
  );

  cmc_comp #(.ACC_W(ACC_W)) u_comp_im (
    .clk  (clk),
    .acc  (acc_im_r),
    .gain (gain_r),
    .sq   (sq_im)
  );

  // output register
  logic                        out_valid_r;
  logic [cmc_pkg::SCORE_W-1:0] score_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      score_r <= cmc_pkg::SCORE_W'(sq_re) + cmc_pkg::SCORE_W'(sq_im);
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.score = score_r;

endmodule

>>> sv/cmc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmc_checker
// Port-level checks on the correlator, bound to the top level.
// ----------------------------------------------------------------------------
module cmc_checker #(
  parameter int TAP_COUNT = cmc_pkg::TAP_COUNT_DEF
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        in_func,
  input logic                        in_block_start,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [cmc_pkg::SCORE_W-1:0] out_score
);

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("score dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_score))
    else $error("score changed while stalled");

  a_tap_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_func == cmc_pkg::FUNC_TAP) |=> in_ready)
    else $error("tap write stalled the input");

  a_start_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_func == cmc_pkg::FUNC_SAMPLE) && in_block_start && (TAP_COUNT > 1)
      |=> in_ready)
    else $error("first sample of a buffer started a window");

  a_score_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("score appeared without a window computation");

endmodule

bind complex_matched_correlator cmc_checker #(.TAP_COUNT(TAP_COUNT)) u_cmc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .in_func        (in_ch.func),
  .in_block_start (in_ch.block_start),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_score      (out_ch.score)
);
